FILE: sv/text_console_writer_unit_defines.svh
// assertion macros shared by the console writer rtl
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define TCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never be seen outside reset
`define TCW_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `TCW_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define TCW_ASSERT(lbl, clk, rstn, prop, msg)
`define TCW_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = ROWS * COLUMNS;

  // internal widths derived from the geometry
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned SUM_W  = ADDR_W + 1;
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);

  // fixed field widths of the stream words
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned OCOL_W  = 7;
  localparam int unsigned OROW_W  = 5;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned OPAD_W  = OUT_W - CELL_W - OCOL_W - OROW_W;

  // character and attribute codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'd7;

  // word kinds carried in tuser
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_BLANK
  } state_e;

endpackage

`default_nettype wire

FILE: sv/text_console_writer_unit.sv
// text console writer
// s_axis carries one request word: tuser selects put (0) or read (1), tdata holds
// the character code and the cell index. m_axis returns one word per request with
// the cell read (0 for a put) and the write position after the request.
// cfg_we_i / cfg_wdata_i set the colour byte used for puts and for blanking; the user
// must write it only while no request is in flight, which the block does not enforce.
// the screen is one single-port-write, registered-read memory of ROWS x COLUMNS
// cells arranged as a ring of rows, so scrolling moves a top-row pointer and only
// blanks one row instead of copying the whole screen.
// a put's answer is loaded into the output register as the put is taken; a read's
// answer goes through the registered memory read and ST_READ first. a put that
// scrolls then blanks all COLUMNS cells of the new bottom row before the next word is taken.
// after reset the memory is filled with 0x0720 one cell a cycle, all CELLS cells,
// during which s_axis_tready is low; cfg writes are taken throughout.
// the result sits in an output register: a new word is taken while it waits as
// long as it drains in the same cycle; a stalled receiver holds the input off.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // colour register
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // char_code[7:0], cell_index[18:8], zero pad
  input  wire logic [0:0]  s_axis_tuser,  // func[0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // cell_data[15:0], write_col[22:16],
                                          // write_row[27:23], zero pad
);

  localparam int unsigned AW = tcw_pkg::ADDR_W;
  localparam int unsigned SW = tcw_pkg::SUM_W;

  // controller and position state
  tcw_pkg::state_e                state_q, state_d;
  logic [AW-1:0]                  sweep_q, sweep_d;
  logic [tcw_pkg::COL_W-1:0]      pos_col_q, pos_col_d;
  logic [tcw_pkg::ROW_W-1:0]      pos_row_q, pos_row_d;
  logic [AW-1:0]                  row_base_q, row_base_d;
  logic [AW-1:0]                  top_base_q, top_base_d;
  logic [tcw_pkg::ATTR_W-1:0]     color_q;
  logic [tcw_pkg::ATTR_W-1:0]     blank_attr_q, blank_attr_d;
  logic                           rd_ok_q, rd_ok_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [tcw_pkg::CELL_W-1:0]     out_data_q, out_data_d;
  logic [tcw_pkg::OCOL_W-1:0]     out_col_q, out_col_d;
  logic [tcw_pkg::OROW_W-1:0]     out_row_q, out_row_d;

  // request fields
  logic                           in_fire;
  logic                           in_func;
  logic [tcw_pkg::CHAR_W-1:0]     in_char;
  logic [tcw_pkg::IDX_W-1:0]      in_idx;

  // datapath helpers
  logic                           put_fire;
  logic                           wrap;
  logic                           scroll;
  logic                           sweep_last;
  logic [SW-1:0]                  put_sum;
  logic [SW-1:0]                  blank_sum;
  logic [SW-1:0]                  rd_sum;
  logic [SW-1:0]                  row_adv;
  logic [SW-1:0]                  top_adv;
  logic [tcw_pkg::COL_W-1:0]      col_next;
  logic [tcw_pkg::ROW_W-1:0]      row_next;

  // memory ports
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
  logic                           ram_re;
  logic [AW-1:0]                  ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_rdata;

  // unpack the request word
  assign in_func = s_axis_tuser[0];
  assign in_char = s_axis_tdata[7:0];
  assign in_idx  = s_axis_tdata[18:8];

  assign s_axis_tready = (state_q == tcw_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign put_fire      = in_fire && (in_func == tcw_pkg::FUNC_PUT);

  // position advance for a put
  assign wrap     = (in_char == tcw_pkg::NEWLINE_CODE) ||
                    (pos_col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
  assign scroll   = wrap && (pos_row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign col_next = wrap ? '0 : pos_col_q + tcw_pkg::COL_W'(1);
  assign row_next = (wrap && !scroll) ? pos_row_q + tcw_pkg::ROW_W'(1) : pos_row_q;

  // ring of physical rows: next row start, wrapping at the end of the memory
  assign row_adv = SW'(row_base_q) + SW'(tcw_pkg::COLUMNS);
  assign top_adv = SW'(top_base_q) + SW'(tcw_pkg::COLUMNS);

  // physical addresses
  assign put_sum   = SW'(row_base_q) + SW'(pos_col_q);
  assign blank_sum = SW'(row_base_q) + SW'(sweep_q);
  assign rd_sum    = SW'(in_idx) + SW'(top_base_q);

  assign sweep_last = (state_q == tcw_pkg::ST_CLEAR) ?
                      (sweep_q == AW'(tcw_pkg::CELLS - 1)) :
                      (sweep_q == AW'(tcw_pkg::COLUMNS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        if (sweep_last) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_fire && (in_func == tcw_pkg::FUNC_READ)) begin
          state_d = tcw_pkg::ST_READ;
        end else if (put_fire && scroll) begin
          state_d = tcw_pkg::ST_BLANK;
        end
      end
      tcw_pkg::ST_READ: begin
        state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_BLANK: begin
        if (sweep_last) state_d = tcw_pkg::ST_IDLE;
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // sweep counter for the clearing pass and row blanking
  always_comb begin
    sweep_d = '0;
    if ((state_q == tcw_pkg::ST_CLEAR || state_q == tcw_pkg::ST_BLANK) && !sweep_last) begin
      sweep_d = sweep_q + AW'(1);
    end
  end

  // position and ring pointers
  always_comb begin
    pos_col_d    = pos_col_q;
    pos_row_d    = pos_row_q;
    row_base_d   = row_base_q;
    top_base_d   = top_base_q;
    blank_attr_d = blank_attr_q;
    if (put_fire) begin
      pos_col_d = col_next;
      pos_row_d = row_next;
      if (scroll) begin
        // old top row becomes the new bottom row
        row_base_d   = top_base_q;
        top_base_d   = (top_adv >= SW'(tcw_pkg::CELLS)) ?
                       AW'(top_adv - SW'(tcw_pkg::CELLS)) : AW'(top_adv);
        blank_attr_d = color_q;
      end else if (wrap) begin
        row_base_d = (row_adv >= SW'(tcw_pkg::CELLS)) ?
                     AW'(row_adv - SW'(tcw_pkg::CELLS)) : AW'(row_adv);
      end
    end
  end

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CODE};
    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        ram_we    = put_fire;
        ram_waddr = AW'(put_sum);
        ram_wdata = {color_q, in_char};
      end
      tcw_pkg::ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(blank_sum);
        ram_wdata = {blank_attr_q, tcw_pkg::BLANK_CODE};
      end
      default: ram_we = 1'b0;
    endcase
  end

  // read request, rotated by the top row pointer
  always_comb begin
    ram_re    = in_fire && (in_func == tcw_pkg::FUNC_READ);
    ram_raddr = (rd_sum >= SW'(tcw_pkg::CELLS)) ?
                AW'(rd_sum - SW'(tcw_pkg::CELLS)) : AW'(rd_sum);
    rd_ok_d   = rd_ok_q;
    if (ram_re) begin
      rd_ok_d = (32'(in_idx) < 32'(tcw_pkg::CELLS));
    end
  end

  // output register load and drain
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    if (put_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_col_d   = tcw_pkg::OCOL_W'(col_next);
      out_row_d   = tcw_pkg::OROW_W'(row_next);
    end else if (state_q == tcw_pkg::ST_READ) begin
      out_valid_d = 1'b1;
      out_data_d  = rd_ok_q ? ram_rdata : '0;
      out_col_d   = tcw_pkg::OCOL_W'(pos_col_q);
      out_row_d   = tcw_pkg::OROW_W'(pos_row_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      sweep_q     <= '0;
      pos_col_q   <= '0;
      pos_row_q   <= '0;
      row_base_q  <= '0;
      top_base_q  <= '0;
      color_q     <= tcw_pkg::RESET_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      pos_col_q   <= pos_col_d;
      pos_row_q   <= pos_row_d;
      row_base_q  <= row_base_d;
      top_base_q  <= top_base_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    blank_attr_q <= blank_attr_d;
    rd_ok_q      <= rd_ok_d;
    out_data_q   <= out_data_d;
    out_col_q    <= out_col_d;
    out_row_q    <= out_row_d;
  end

  // screen memory
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {tcw_pkg::OPAD_W'(0), out_row_q, out_col_q, out_data_q};

  // checks
  `TCW_ASSERT(a_waddr_in_range, clk_i, rst_ni, ram_we |-> (32'(ram_waddr) < 32'(tcw_pkg::CELLS)), "memory write outside the screen")
  `TCW_ASSERT(a_read_slot_free, clk_i, rst_ni, (state_q == tcw_pkg::ST_READ) |-> !out_valid_q, "read data arrives while a result is still pending")
  `TCW_ASSERT(a_newline_col, clk_i, rst_ni, (put_fire && (in_char == tcw_pkg::NEWLINE_CODE)) |=> (pos_col_q == '0), "newline did not return the column")
  `TCW_ASSERT_NEVER(a_blank_no_input, clk_i, rst_ni, (state_q == tcw_pkg::ST_BLANK) && s_axis_tready, "input taken during row blanking")

endmodule

`default_nettype wire

FILE: sv/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
